>>> design/itp_pkg.sv
// Shared types, codes and helper functions of the infix-to-postfix converter.
// No dependencies; compiled before every other design file.
package itp_pkg;

  // Default number of cells in the operator stack.
  localparam int unsigned StackDepthDef = 64;

  localparam logic [7:0] CharAdd   = 8'h2B; // '+'
  localparam logic [7:0] CharSub   = 8'h2D; // '-'
  localparam logic [7:0] CharMul   = 8'h2A; // '*'
  localparam logic [7:0] CharDiv   = 8'h2F; // '/'
  localparam logic [7:0] CharPow   = 8'h5E; // '^'
  localparam logic [7:0] CharOpen  = 8'h28; // '('
  localparam logic [7:0] CharClose = 8'h29; // ')'

  // Stacked operator codes.
  typedef enum logic [2:0] {
    OP_OPEN = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_POW  = 3'd5
  } op_code_e;

  typedef enum logic [2:0] {
    ST_OK              = 3'd0,
    ST_INVALID         = 3'd1,
    ST_OVERFLOW        = 3'd2,
    ST_UNMATCHED_CLOSE = 3'd3,
    ST_UNMATCHED_OPEN  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CC_OPERAND,
    CC_OPEN,
    CC_CLOSE,
    CC_OPERATOR,
    CC_INVALID
  } char_class_e;

  // Stack command, shared by every cell of the row.
  typedef struct packed {
    logic init;  // back to a lone sentinel
    logic push;  // shift down, new code enters at the top
    logic pop;   // shift up
  } stk_cmd_t;

  function automatic op_code_e op_of_char(input logic [7:0] ch);
    op_code_e op;
    case (ch)
      CharAdd: op = OP_ADD;
      CharSub: op = OP_SUB;
      CharMul: op = OP_MUL;
      CharDiv: op = OP_DIV;
      CharPow: op = OP_POW;
      default: op = OP_OPEN;
    endcase
    return op;
  endfunction

  function automatic logic [7:0] char_of_op(input op_code_e op);
    logic [7:0] ch;
    case (op)
      OP_ADD:  ch = CharAdd;
      OP_SUB:  ch = CharSub;
      OP_MUL:  ch = CharMul;
      OP_DIV:  ch = CharDiv;
      OP_POW:  ch = CharPow;
      default: ch = CharOpen;
    endcase
    return ch;
  endfunction

  function automatic logic [1:0] prec_of_op(input op_code_e op);
    logic [1:0] p;
    case (op)
      OP_ADD, OP_SUB: p = 2'd1;
      OP_MUL, OP_DIV: p = 2'd2;
      OP_POW:         p = 2'd3;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic char_class_e class_of_char(input logic [7:0] ch);
    char_class_e cc;
    if ((ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A) ||
        (ch >= 8'h61 && ch <= 8'h7A)) begin
      cc = CC_OPERAND;
    end else if (ch == CharOpen) begin
      cc = CC_OPEN;
    end else if (ch == CharClose) begin
      cc = CC_CLOSE;
    end else if (op_of_char(ch) != OP_OPEN) begin
      cc = CC_OPERATOR;
    end else begin
      cc = CC_INVALID;
    end
    return cc;
  endfunction

endpackage

>>> design/itp_if.sv
// Valid/ready channel interfaces of the infix-to-postfix converter.
// Depends on nothing; follows itp_pkg in compile order.
interface itp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_in;

  modport source (output valid, output kind, output char_in, input ready);
  modport sink   (input valid, input kind, input char_in, output ready);
endinterface

interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] sym_out;
  logic       sym_valid;
  logic [2:0] status;
  logic       done_res;

  modport source (output valid, output sym_out, output sym_valid, output status,
                  output done_res, input ready);
  modport sink   (input valid, input sym_out, input sym_valid, input status,
                  input done_res, output ready);
endinterface

>>> design/itp_stack_cell.sv
// One cell of the shifting operator stack: holds one operator code.
// Depends on itp_pkg.
module itp_stack_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  itp_pkg::stk_cmd_t  cmd_i,
  input  itp_pkg::op_code_e  above_i,  // neighbour nearer the top
  input  itp_pkg::op_code_e  below_i,  // neighbour nearer the bottom
  output itp_pkg::op_code_e  code_o
);
  import itp_pkg::*;

  op_code_e code_q, code_d;

  always_comb begin
    code_d = code_q;
    if (cmd_i.init) begin
      code_d = OP_OPEN;
    end else if (cmd_i.push) begin
      code_d = above_i;
    end else if (cmd_i.pop) begin
      code_d = below_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= OP_OPEN;
    end else begin
      code_q <= code_d;
    end
  end

  assign code_o = code_q;

endmodule

>>> design/itp_stack.sv
// Operator stack as a row of shifting cells; cell 0 is the top of stack.
// Depends on itp_pkg and itp_stack_cell.
module itp_stack #(
  parameter int unsigned Depth = itp_pkg::StackDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  itp_pkg::stk_cmd_t  cmd_i,
  input  itp_pkg::op_code_e  push_code_i,
  output itp_pkg::op_code_e  top_o
);
  import itp_pkg::*;

  op_code_e codes [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    op_code_e above, below;
    if (i == 0) begin : g_top
      assign above = push_code_i;
    end else begin : g_mid_a
      assign above = codes[i-1];
    end
    if (i == Depth - 1) begin : g_bot
      assign below = OP_OPEN;
    end else begin : g_mid_b
      assign below = codes[i+1];
    end

    itp_stack_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd_i),
      .above_i (above),
      .below_i (below),
      .code_o  (codes[i])
    );
  end

  assign top_o = codes[0];

endmodule

>>> design/infix_to_postfix_converter.sv
// Infix-to-postfix converter, top level: sequencer and output register.
// Depends on itp_pkg, itp_if (itp_in_if, itp_out_if) and itp_stack.
//
// Usage
//   in_i  : one word per infix character (kind = 0) or an end-of-expression
//           word (kind = 1). Accepted on valid && ready.
//   out_o : one word per postfix symbol (sym_valid = 1), and after each end
//           word one status word (done_res = 1, status = error code).
//   Operands pass straight through; operators go through a stack of
//   STACK_DEPTH shifting cells that starts each expression with a '('
//   sentinel. The first error is sticky: later characters are dropped and
//   the code is reported in the status word.
// Timing
//   A word is taken in S_IDLE, then worked off in S_WORK one stack step per
//   cycle while the output register is free; an operator, ')' or end word
//   pops one operator per step, and an end word ends in S_STATUS with its
//   status word. A new word is taken only once the last is finished. A
//   symbol sits in the output register the cycle after it is produced.
// Reset and stalls
//   rst_ni clears the stack to the lone sentinel, the error code to ok and
//   the output register to empty. No clearing pass is needed. If out_o
//   stalls with a word held, the sequencer waits on the next symbol and
//   in_i.ready stays low until the current word is finished.
module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = itp_pkg::StackDepthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  itp_in_if.sink  in_i,
  itp_out_if.source out_o
);
  import itp_pkg::*;

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(STACK_DEPTH);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WORK,
    S_STATUS
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;   // entries on the stack
  status_e         err_q, err_d;   // sticky error code
  logic            kind_q, kind_d;
  logic [7:0]      char_q, char_d;

  // output register
  logic       ovld_q, ovld_d;
  logic [7:0] osym_q, osym_d;
  logic       osv_q, osv_d;
  logic [2:0] ost_q, ost_d;
  logic       odone_q, odone_d;

  stk_cmd_t    stk_cmd;
  op_code_e    top;
  op_code_e    item_op;
  char_class_e cls;
  logic        out_free;
  logic        in_acc;

  itp_stack #(.Depth(STACK_DEPTH)) u_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (stk_cmd),
    .push_code_i (item_op),
    .top_o       (top)
  );

  assign item_op  = op_of_char(char_q);
  assign cls      = class_of_char(char_q);
  assign out_free = !ovld_q || out_o.ready;
  assign in_acc   = in_i.valid && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    kind_d  = kind_q;
    char_d  = char_q;
    stk_cmd = '0;
    ovld_d  = ovld_q && !out_o.ready;
    osym_d  = osym_q;
    osv_d   = osv_q;
    ost_d   = ost_q;
    odone_d = odone_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          kind_d  = in_i.kind;
          char_d  = in_i.char_in;
          state_d = S_WORK;
        end
      end

      S_WORK: begin
        if (kind_q && err_q != ST_OK) begin
          state_d = S_STATUS;
        end else if (!kind_q && err_q != ST_OK) begin
          state_d = S_IDLE;  // sticky error: word dropped
        end else if (kind_q || cls == CC_CLOSE) begin
          // pop down to the matching '('; the end word closes the sentinel
          if (cnt_q == '0) begin
            err_d   = ST_UNMATCHED_CLOSE;
            state_d = kind_q ? S_STATUS : S_IDLE;
          end else if (top == OP_OPEN) begin
            stk_cmd.pop = 1'b1;
            cnt_d       = cnt_q - CntOne;
            if (kind_q) begin
              if (cnt_q != CntOne) err_d = ST_UNMATCHED_OPEN;
              state_d = S_STATUS;
            end else begin
              state_d = S_IDLE;
            end
          end else if (out_free) begin
            stk_cmd.pop = 1'b1;
            cnt_d       = cnt_q - CntOne;
            ovld_d      = 1'b1;
            osym_d      = char_of_op(top);
            osv_d       = 1'b1;
            ost_d       = ST_OK;
            odone_d     = 1'b0;
          end
        end else begin
          case (cls)
            CC_OPEN: begin
              if (cnt_q == CntFull) begin
                err_d = ST_OVERFLOW;
              end else begin
                stk_cmd.push = 1'b1;
                cnt_d        = cnt_q + CntOne;
              end
              state_d = S_IDLE;
            end
            CC_OPERATOR: begin
              if (cnt_q == '0) begin
                err_d   = ST_UNMATCHED_CLOSE;
                state_d = S_IDLE;
              end else if (top == OP_OPEN || prec_of_op(top) < prec_of_op(item_op)) begin
                if (cnt_q == CntFull) begin
                  err_d = ST_OVERFLOW;
                end else begin
                  stk_cmd.push = 1'b1;
                  cnt_d        = cnt_q + CntOne;
                end
                state_d = S_IDLE;
              end else if (out_free) begin
                stk_cmd.pop = 1'b1;
                cnt_d       = cnt_q - CntOne;
                ovld_d      = 1'b1;
                osym_d      = char_of_op(top);
                osv_d       = 1'b1;
                ost_d       = ST_OK;
                odone_d     = 1'b0;
              end
            end
            CC_OPERAND: begin
              if (out_free) begin
                ovld_d  = 1'b1;
                osym_d  = char_q;
                osv_d   = 1'b1;
                ost_d   = ST_OK;
                odone_d = 1'b0;
                state_d = S_IDLE;
              end
            end
            default: begin
              err_d   = ST_INVALID;
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_STATUS: begin
        if (out_free) begin
          ovld_d       = 1'b1;
          osym_d       = '0;
          osv_d        = 1'b0;
          ost_d        = err_q;
          odone_d      = 1'b1;
          stk_cmd.init = 1'b1;  // fresh sentinel for the next expression
          cnt_d        = CntOne;
          err_d        = ST_OK;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= CntOne;
      err_q   <= ST_OK;
      ovld_q  <= 1'b0;
      kind_q  <= 1'b0;
      char_q  <= '0;
      osym_q  <= '0;
      osv_q   <= 1'b0;
      ost_q   <= '0;
      odone_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
      ovld_q  <= ovld_d;
      kind_q  <= kind_d;
      char_q  <= char_d;
      osym_q  <= osym_d;
      osv_q   <= osv_d;
      ost_q   <= ost_d;
      odone_q <= odone_d;
    end
  end

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = ovld_q;
  assign out_o.sym_out   = osym_q;
  assign out_o.sym_valid = osv_q;
  assign out_o.status    = ost_q;
  assign out_o.done_res  = odone_q;

endmodule

>>> bench/tb.sv
// Self-checking bench for infix_to_postfix_converter: a shunting-yard predictor
// checks every postfix and status word. Needs itp_pkg, itp_if and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itp_pkg::*;

  localparam int unsigned StackDepth = StackDepthDef;
  localparam int PhaseWords = 60;             // random words queued per phase, at least
  localparam int DrainCycles = StackDepth + 16; // covers an end word that pops a full stack
  localparam int CycleLimit = 400000;

  // Precedence and character of each stacked operator code, indexed by code
  localparam logic [1:0] OpRank [0:5] = '{2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3};
  localparam logic [7:0] OpSym [0:5] =
    '{CharOpen, CharAdd, CharSub, CharMul, CharDiv, CharPow};

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
  } infix_word_t;

  typedef struct packed {
    logic [7:0] sym;
    logic       sym_valid;
    status_e    status;
    logic       done_res;
  } postfix_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  itp_in_if  in_if ();
  itp_out_if out_if ();

  infix_to_postfix_converter #(
    .STACK_DEPTH(StackDepth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  infix_word_t   infix_backlog[$]; // words still to offer, front is on the bus
  postfix_word_t postfix_due[$];   // words the block still owes
  int            queued_words;
  int            mismatch_count = 0;
  int            cycle_count = 0;
  int unsigned   sender_idle_pct = 0;
  int unsigned   stall_pct = 0;

  // Predictor state: operator stack, its fill level and the sticky error
  op_code_e held_ops [StackDepth];
  int       held_count;
  status_e  pending_err;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  task automatic due_word(input logic [7:0] sym, input logic sym_valid,
                          input status_e status, input logic done_res);
    postfix_word_t w;
    w.sym       = sym;
    w.sym_valid = sym_valid;
    w.status    = status;
    w.done_res  = done_res;
    postfix_due.push_back(w);
  endtask

  task automatic push_op(input op_code_e code);
    if (held_count >= StackDepth) begin
      pending_err = ST_OVERFLOW;
    end else begin
      held_ops[held_count] = code;
      held_count++;
    end
  endtask

  // Pop and emit down to the nearest '(' which is consumed; an empty stack
  // before one turns up means a stray close.
  task automatic unwind_group();
    logic searching;
    searching = 1'b1;
    while (searching) begin
      if (held_count == 0) begin
        pending_err = ST_UNMATCHED_CLOSE;
        searching   = 1'b0;
      end else begin
        held_count--;
        if (held_ops[held_count] == OP_OPEN) begin
          searching = 1'b0;
        end else begin
          due_word(OpSym[held_ops[held_count]], 1'b1, ST_OK, 1'b0);
        end
      end
    end
  endtask

  task automatic convert_word(input logic kind, input logic [7:0] ch);
    op_code_e incoming;
    logic     popping;
    incoming = OP_OPEN;
    case (ch)
      CharAdd: incoming = OP_ADD;
      CharSub: incoming = OP_SUB;
      CharMul: incoming = OP_MUL;
      CharDiv: incoming = OP_DIV;
      CharPow: incoming = OP_POW;
      default: incoming = OP_OPEN;
    endcase
    if (kind) begin
      // End word: implicit close, status word, then back to a lone sentinel
      if (pending_err == ST_OK) begin
        unwind_group();
        if (pending_err == ST_OK && held_count != 0) pending_err = ST_UNMATCHED_OPEN;
      end
      due_word(8'h00, 1'b0, pending_err, 1'b1);
      held_ops[0] = OP_OPEN;
      held_count  = 1;
      pending_err = ST_OK;
    end else if (pending_err == ST_OK) begin
      if (ch inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) begin
        due_word(ch, 1'b1, ST_OK, 1'b0);
      end else if (ch == CharOpen) begin
        push_op(OP_OPEN);
      end else if (ch == CharClose) begin
        unwind_group();
      end else if (incoming != OP_OPEN) begin
        // Left-associative: pop while the top ranks equal or higher
        popping = 1'b1;
        while (popping) begin
          if (held_count == 0) begin
            pending_err = ST_UNMATCHED_CLOSE;
            popping     = 1'b0;
          end else if (held_ops[held_count - 1] == OP_OPEN ||
                       OpRank[held_ops[held_count - 1]] < OpRank[incoming]) begin
            popping = 1'b0;
          end else begin
            held_count--;
            due_word(OpSym[held_ops[held_count]], 1'b1, ST_OK, 1'b0);
          end
        end
        if (pending_err == ST_OK) push_op(incoming);
      end else begin
        pending_err = ST_INVALID;
      end
    end
    // with an error pending, characters are dropped silently
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic put_char(input logic [7:0] ch);
    infix_word_t w;
    w.kind = 1'b0;
    w.ch   = ch;
    infix_backlog.push_back(w);
    queued_words++;
  endtask

  // char_in is don't-care on an end word, so it carries junk
  task automatic put_end(input logic [7:0] junk);
    infix_word_t w;
    w.kind = 1'b1;
    w.ch   = junk;
    infix_backlog.push_back(w);
    queued_words++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  function automatic logic [7:0] pick_operand();
    int unsigned r;
    r = $urandom_range(61);
    if (r < 10) return 8'h30 + r[7:0];
    else if (r < 36) return 8'h41 + r[7:0] - 8'd10;
    else return 8'h61 + r[7:0] - 8'd36;
  endfunction

  function automatic logic [7:0] pick_operator();
    logic [7:0] ch;
    case ($urandom_range(4))
      0:       ch = CharAdd;
      1:       ch = CharSub;
      2:       ch = CharMul;
      3:       ch = CharDiv;
      default: ch = CharPow;
    endcase
    return ch;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: valid stays up until the word is taken; idles only between words
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive
    logic taken;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      taken = in_if.valid && in_if.ready;
      if (taken) begin
        convert_word(in_if.kind, in_if.char_in);
        void'(infix_backlog.pop_front());
      end
      if (!in_if.valid || taken) begin
        if (infix_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_if.valid   <= 1'b1;
          in_if.kind    <= infix_backlog[0].kind;
          in_if.char_in <= infix_backlog[0].ch;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, every taken word checked against the oldest
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch
    postfix_word_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (postfix_due.size() == 0) begin
          $error("unexpected word: sym_out %h status %0d done_res %b",
                 out_if.sym_out, out_if.status, out_if.done_res);
          mismatch_count++;
        end else begin
          want = postfix_due.pop_front();
          if (out_if.sym_out !== want.sym) begin
            $error("sym_out: expected %h, got %h", want.sym, out_if.sym_out);
            mismatch_count++;
          end
          if (out_if.sym_valid !== want.sym_valid) begin
            $error("sym_valid: expected %b, got %b", want.sym_valid, out_if.sym_valid);
            mismatch_count++;
          end
          if (out_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_if.status);
            mismatch_count++;
          end
          if (out_if.done_res !== want.done_res) begin
            $error("done_res: expected %b, got %b", want.done_res, out_if.done_res);
            mismatch_count++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: directed expressions, then four phases, with and without sender idling and output stalls, of random ones
  // ---------------------------------------------------------------------------
  initial begin
    int       expr_count;
    int       depth;
    int       operands_left;
    int       nest;
    logic     want_operand;
    logic     building;

    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.kind    = 1'b0;
    in_if.char_in = 8'h00;
    out_if.ready  = 1'b0;
    held_ops[0]   = OP_OPEN;
    held_count    = 1;
    pending_err   = ST_OK;
    expr_count    = 0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: every operator and operand edge, mixed ranks, then the
    // stray-close, unclosed-open and invalid-character errors one by one
    put_text("(A+9)^z/0-Z*a");
    put_end(8'hFF);
    put_end(8'h00);                // empty expression
    put_char(CharClose);           // stray close
    put_end(8'h5A);
    put_char(CharOpen);            // '(' never closed
    put_end(8'h81);
    put_char(8'h00);               // NUL is not a symbol ...
    put_char(8'h62);               // ... and this gets dropped
    put_end(8'h3C);
    put_char(8'hFF);
    put_end(8'h00);
    while (infix_backlog.size() != 0) @(posedge clk_i);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 77; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 77; end
        default: begin sender_idle_pct = 28; stall_pct = 28; end
      endcase
      queued_words = 0;
      while (queued_words < PhaseWords) begin
        expr_count++;
        if (expr_count % 16 == 5) begin
          // Deep nesting around the stack limit: below it, full, or over it
          nest = $urandom_range(56, 66);
          for (int i = 0; i < nest; i++) begin
            put_char(CharOpen);
            if ($urandom_range(3) == 0) begin
              put_char(pick_operand());
              put_char(pick_operator());
            end
          end
          put_char(pick_operand());
          repeat (nest) put_char(CharClose);
        end else begin
          case ($urandom_range(19))
            0, 1, 2: begin
              // ragged: symbols in any order, brackets unbalanced
              repeat ($urandom_range(1, 8)) begin
                case ($urandom_range(9))
                  0, 1, 2, 3: put_char(pick_operand());
                  4, 5, 6:    put_char(pick_operator());
                  7, 8:       put_char(CharOpen);
                  default:    put_char(CharClose);
                endcase
              end
            end
            3, 4: begin
              // a few sane symbols, one arbitrary byte, then more
              repeat ($urandom_range(0, 2)) begin
                put_char(pick_operand());
                put_char(pick_operator());
              end
              put_char(8'($urandom_range(255)));
              repeat ($urandom_range(0, 3)) put_char(8'($urandom_range(255)));
            end
            default: begin
              // well-formed expression with random nesting
              depth         = 0;
              operands_left = $urandom_range(1, 10);
              want_operand  = 1'b1;
              building      = 1'b1;
              while (building) begin
                if (want_operand) begin
                  if (depth < 6 && $urandom_range(3) == 0) begin
                    put_char(CharOpen);
                    depth++;
                  end else begin
                    put_char(pick_operand());
                    operands_left--;
                    want_operand = 1'b0;
                  end
                end else if (depth > 0 && $urandom_range(2) == 0) begin
                  put_char(CharClose);
                  depth--;
                end else if (operands_left > 0) begin
                  put_char(pick_operator());
                  want_operand = 1'b1;
                end else begin
                  building = 1'b0;
                end
              end
              repeat (depth) put_char(CharClose);
            end
          endcase
        end
        put_end(8'($urandom_range(255)));
      end
      while (infix_backlog.size() != 0) @(posedge clk_i);
    end

    while (postfix_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
design/itp_pkg.sv
design/itp_if.sv
design/itp_stack_cell.sv
design/itp_stack.sv
design/infix_to_postfix_converter.sv
bench/tb.sv
